// ===== design/eased_tween_interpolator_top_assert.svh =====
// Assertion macros for the eased tween interpolator.
`ifndef EASED_TWEEN_INTERPOLATOR_TOP_ASSERT_SVH
`define EASED_TWEEN_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define ETI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define ETI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/eti_pkg.sv =====
`timescale 1ns / 1ps
package eti_pkg;

	localparam int STEP_BITS = 4;
	localparam int EPS_BITS = 31;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 31'd66;
	localparam int TSTEP_BITS = 16;
	localparam int ADDR_BITS = 3;
	localparam logic IDX_EPS = 1'b0;

	localparam logic [1:0] CMD_SNAP = 2'd0;
	localparam logic [1:0] CMD_TWEEN = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;

	localparam logic [1:0] EASE_LINEAR = 2'd0;
	localparam logic [1:0] EASE_OUT = 2'd1;
	localparam logic [1:0] EASE_INOUT = 2'd2;

	localparam logic [STEP_BITS-1:0] S_WAIT = 4'd0;
	localparam logic [STEP_BITS-1:0] S_EXEC = 4'd1;
	localparam logic [STEP_BITS-1:0] S_DIV = 4'd2;
	localparam logic [STEP_BITS-1:0] S_PREP = 4'd3;
	localparam logic [STEP_BITS-1:0] S_SQ = 4'd4;
	localparam logic [STEP_BITS-1:0] S_CUBE = 4'd5;
	localparam logic [STEP_BITS-1:0] S_HI = 4'd6;
	localparam logic [STEP_BITS-1:0] S_LO = 4'd7;
	localparam logic [STEP_BITS-1:0] S_APPLY = 4'd8;
	localparam logic [STEP_BITS-1:0] S_REPORT = 4'd9;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_EXEC,
		OP_DIV,
		OP_PREP,
		OP_SQ,
		OP_CUBE,
		OP_HI,
		OP_LO,
		OP_APPLY,
		OP_REPORT
	} op_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_NO_ACCEPT,
		C_NO_WORK,
		C_COUNT_NZ,
		C_LINEAR,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t                  op;
		cond_t                cond;
		logic [STEP_BITS-1:0] jump_to;
		logic [STEP_BITS-1:0] next_to;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic tick_go;
		logic count_nz;
		logic linear;
		logic out_busy;
	} flags_t;

	function automatic ctrl_t rom_word(input logic [STEP_BITS-1:0] s);
		ctrl_t w;
		unique case (s)
			S_WAIT:   w = '{op: OP_WAIT, cond: C_NO_ACCEPT, jump_to: S_WAIT, next_to: S_EXEC};
			S_EXEC:   w = '{op: OP_EXEC, cond: C_NO_WORK, jump_to: S_REPORT, next_to: S_DIV};
			S_DIV:    w = '{op: OP_DIV, cond: C_COUNT_NZ, jump_to: S_DIV, next_to: S_PREP};
			S_PREP:   w = '{op: OP_PREP, cond: C_LINEAR, jump_to: S_HI, next_to: S_SQ};
			S_SQ:     w = '{op: OP_SQ, cond: C_NONE, jump_to: S_WAIT, next_to: S_CUBE};
			S_CUBE:   w = '{op: OP_CUBE, cond: C_NONE, jump_to: S_WAIT, next_to: S_HI};
			S_HI:     w = '{op: OP_HI, cond: C_NONE, jump_to: S_WAIT, next_to: S_LO};
			S_LO:     w = '{op: OP_LO, cond: C_NONE, jump_to: S_WAIT, next_to: S_APPLY};
			S_APPLY:  w = '{op: OP_APPLY, cond: C_NONE, jump_to: S_WAIT, next_to: S_REPORT};
			S_REPORT: w = '{op: OP_REPORT, cond: C_OUT_BUSY, jump_to: S_REPORT, next_to: S_WAIT};
			default:  w = '{op: OP_NOP, cond: C_NONE, jump_to: S_WAIT, next_to: S_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== design/eti_item_if.sv =====
`timescale 1ns / 1ps
interface eti_item_if #(
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS = 24
);
	logic                                valid;
	logic                                ready;
	logic [1:0]                          command;
	logic signed [VALUE_BITS-1:0]        value_in;
	logic [TIME_BITS-1:0]                duration_ticks;
	logic [1:0]                          ease_mode;
	logic [eti_pkg::TSTEP_BITS-1:0]      time_step;

	modport source (
		output valid, command, value_in, duration_ticks, ease_mode, time_step,
		input  ready
	);
	modport sink (
		input  valid, command, value_in, duration_ticks, ease_mode, time_step,
		output ready
	);
endinterface

// ===== design/eti_result_if.sv =====
`timescale 1ns / 1ps
interface eti_result_if #(
	parameter int VALUE_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] current_value;
	logic                         still_moving;

	modport source (
		output valid, current_value, still_moving,
		input  ready
	);
	modport sink (
		input  valid, current_value, still_moving,
		output ready
	);
endinterface

// ===== design/eti_seq.sv =====
`timescale 1ns / 1ps
module eti_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  eti_pkg::flags_t flags,
	output eti_pkg::ctrl_t  ctrl
);

	logic [eti_pkg::STEP_BITS-1:0] step_q;
	logic                          take;

	assign ctrl = eti_pkg::rom_word(step_q);

	always_comb begin
		unique case (ctrl.cond)
			eti_pkg::C_NONE:      take = 1'b0;
			eti_pkg::C_NO_ACCEPT: take = !flags.accept;
			eti_pkg::C_NO_WORK:   take = !flags.tick_go;
			eti_pkg::C_COUNT_NZ:  take = flags.count_nz;
			eti_pkg::C_LINEAR:    take = flags.linear;
			eti_pkg::C_OUT_BUSY:  take = flags.out_busy;
			default:              take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= eti_pkg::S_WAIT;
		end else begin
			step_q <= take ? ctrl.jump_to : ctrl.next_to;
		end
	end

endmodule

// ===== design/eased_tween_interpolator_top.sv =====
`timescale 1ns / 1ps
// Animates one signed fixed-point value (FRACTION_BITS fraction bits) toward a target. Each
// transaction on item is a snap, a retarget with duration and ease curve (linear, out-cubic,
// in-out-cubic), or a tick; each one yields exactly one transaction on result with the value
// and a still-moving flag judged against settle_epsilon (APB register at byte address 0,
// reset 66). A small microcode program steps a shared datapath: snap, retarget, an idle tick
// and a zero tick go from the wait step through the execute step to the report step, where
// the result is loaded; a tween tick also passes the divide, prep, square, cube, high, low
// and apply steps, skipping square and cube on the linear curve, and so uses the restoring
// divider for elapsed/duration, one quotient bit per cycle, and the single multiplier used in
// turn for the cube and the scaling of the span. A new item is taken only while the
// sequencer is at its wait step; a result still waiting on result holds the next item at the
// report step, and with it any further acceptance, until result takes the waiting one.
`include "eased_tween_interpolator_top_assert.svh"
module eased_tween_interpolator_top #(
	parameter int VALUE_BITS = 32,
	parameter int TIME_BITS = 24,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	eti_item_if.sink                      item,
	eti_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [eti_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int F = FRACTION_BITS;
	localparam int MUL_A_BITS = (VALUE_BITS - F > F + 1) ? VALUE_BITS - F : F + 1;
	localparam int MUL_P_BITS = MUL_A_BITS + F + 1;
	localparam int CNT_BITS = $clog2(F + 1);
	localparam int SUM_BITS = ((TIME_BITS > eti_pkg::TSTEP_BITS) ? TIME_BITS
		: eti_pkg::TSTEP_BITS) + 1;
	localparam int CMP_BITS = (VALUE_BITS > eti_pkg::EPS_BITS) ? VALUE_BITS
		: eti_pkg::EPS_BITS;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
	localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};

	eti_pkg::ctrl_t  ctrl;
	eti_pkg::flags_t flags;

	eti_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctrl  (ctrl)
	);

	// Item registers
	logic [1:0]                         cmd_q;
	logic signed [VALUE_BITS-1:0]       val_q;
	logic [TIME_BITS-1:0]               dur_q;
	logic [1:0]                         mode_q;
	logic [eti_pkg::TSTEP_BITS-1:0]     tstep_q;

	// Animation state
	logic signed [VALUE_BITS-1:0]       present_q;
	logic signed [VALUE_BITS-1:0]       start_q;
	logic signed [VALUE_BITS-1:0]       goal_q;
	logic [TIME_BITS-1:0]               total_q;
	logic [TIME_BITS-1:0]               spent_q;
	logic [1:0]                         curve_q;
	logic                               running_q;
	logic [eti_pkg::EPS_BITS-1:0]       eps_q;

	// Working registers
	logic [TIME_BITS:0]                 rem_q;
	logic [F:0]                         quot_q;
	logic [CNT_BITS-1:0]                cnt_q;
	logic [F:0]                         u_q;
	logic [F:0]                         sq_q;
	logic [F:0]                         e_q;
	logic [VALUE_BITS-1:0]              mag_q;
	logic                               neg_q;
	logic [VALUE_BITS-1:0]              acc_q;

	logic                               out_valid_q;
	logic signed [VALUE_BITS-1:0]       out_value_q;
	logic                               out_moving_q;

	logic                               in_ready;
	logic                               accept;
	logic                               tick_go;
	logic                               load_out;
	logic                               cfg_write;
	logic [SUM_BITS-1:0]                spent_sum;
	logic [TIME_BITS-1:0]               spent_sat;
	logic                               div_ge;
	logic [TIME_BITS:0]                 rem_sub;
	logic [VALUE_BITS:0]                span;
	logic [VALUE_BITS:0]                span_abs;
	logic [VALUE_BITS:0]                gap;
	logic [VALUE_BITS:0]                gap_abs;
	logic                               moving;
	logic [MUL_A_BITS-1:0]              mul_a;
	logic [F:0]                         mul_b;
	logic [MUL_P_BITS-1:0]              mul_p;
	logic [F:0]                         mul_frac;
	logic [F:0]                         ease_cube;
	logic [F:0]                         ease_x;
	logic [F:0]                         u_x;
	logic                               linear;

	assign in_ready = (ctrl.op == eti_pkg::OP_WAIT);
	assign item.ready = in_ready;
	assign accept = item.valid && in_ready;
	assign tick_go = (cmd_q == eti_pkg::CMD_TICK) && running_q
		&& (tstep_q != '0);
	assign linear = (curve_q != eti_pkg::EASE_OUT) && (curve_q != eti_pkg::EASE_INOUT);

	assign flags.accept = accept;
	assign flags.tick_go = tick_go;
	assign flags.count_nz = (cnt_q != '0);
	assign flags.linear = linear;
	assign flags.out_busy = out_valid_q && !result.ready;

	assign load_out = (ctrl.op == eti_pkg::OP_REPORT) && !flags.out_busy;

	assign result.valid = out_valid_q;
	assign result.current_value = out_value_q;
	assign result.still_moving = out_moving_q;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite
		&& (paddr[eti_pkg::ADDR_BITS-1:2] == eti_pkg::IDX_EPS);
	assign prdata = (paddr[eti_pkg::ADDR_BITS-1:2] == eti_pkg::IDX_EPS)
		? {1'b0, eps_q} : 32'd0;

	assign spent_sum = SUM_BITS'(spent_q) + SUM_BITS'(tstep_q);
	assign spent_sat = (spent_sum > SUM_BITS'(total_q)) ? total_q
		: spent_sum[TIME_BITS-1:0];

	assign div_ge = (rem_q >= {1'b0, total_q});
	assign rem_sub = div_ge ? (rem_q - {1'b0, total_q}) : rem_q;

	assign span = {goal_q[VALUE_BITS-1], goal_q} - {start_q[VALUE_BITS-1], start_q};
	assign span_abs = span[VALUE_BITS] ? (~span + 1'b1) : span;
	assign gap = {goal_q[VALUE_BITS-1], goal_q} - {present_q[VALUE_BITS-1], present_q};
	assign gap_abs = gap[VALUE_BITS] ? (~gap + 1'b1) : gap;
	assign moving = running_q
		|| (CMP_BITS'(gap_abs[VALUE_BITS-1:0]) > CMP_BITS'(eps_q));

	assign u_x = (curve_q == eti_pkg::EASE_OUT) ? (ONE - quot_q)
		: ((quot_q < HALF) ? quot_q : ((ONE - quot_q) << 1));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.op)
			eti_pkg::OP_SQ: begin
				mul_a = MUL_A_BITS'(u_q);
				mul_b = u_q;
			end
			eti_pkg::OP_CUBE: begin
				mul_a = MUL_A_BITS'(sq_q);
				mul_b = u_q;
			end
			eti_pkg::OP_HI: begin
				mul_a = MUL_A_BITS'(mag_q >> F);
				mul_b = e_q;
			end
			eti_pkg::OP_LO: begin
				mul_a = MUL_A_BITS'(mag_q[F-1:0]);
				mul_b = e_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);
	assign mul_frac = mul_p[2*F:F];
	assign ease_cube = mul_frac;
	assign ease_x = (curve_q == eti_pkg::EASE_OUT) ? (ONE - ease_cube)
		: ((quot_q < HALF) ? (ease_cube << 2) : (ONE - (ease_cube >> 1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			start_q <= '0;
			goal_q <= '0;
			total_q <= '0;
			spent_q <= '0;
			curve_q <= eti_pkg::EASE_LINEAR;
			running_q <= 1'b0;
			out_valid_q <= 1'b0;
			eps_q <= eti_pkg::EPS_RESET;
		end else begin
			if (cfg_write) begin
				eps_q <= pwdata[eti_pkg::EPS_BITS-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				eti_pkg::OP_EXEC: begin
					if ((cmd_q == eti_pkg::CMD_SNAP)
						|| ((cmd_q == eti_pkg::CMD_TWEEN) && (dur_q == '0))) begin
						present_q <= val_q;
						start_q <= val_q;
						goal_q <= val_q;
						total_q <= '0;
						spent_q <= '0;
						running_q <= 1'b0;
					end else if (cmd_q == eti_pkg::CMD_TWEEN) begin
						start_q <= present_q;
						goal_q <= val_q;
						total_q <= dur_q;
						spent_q <= '0;
						curve_q <= mode_q;
						running_q <= 1'b1;
					end else if (tick_go) begin
						spent_q <= spent_sat;
					end
				end
				eti_pkg::OP_APPLY: begin
					if (spent_q >= total_q) begin
						present_q <= goal_q;
						running_q <= 1'b0;
					end else begin
						present_q <= neg_q ? (start_q - acc_q) : (start_q + acc_q);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= item.command;
			val_q <= item.value_in;
			dur_q <= item.duration_ticks;
			mode_q <= item.ease_mode;
			tstep_q <= item.time_step;
		end
		unique case (ctrl.op)
			eti_pkg::OP_EXEC: begin
				rem_q <= {1'b0, spent_sat};
				quot_q <= '0;
				cnt_q <= CNT_BITS'(F);
			end
			eti_pkg::OP_DIV: begin
				rem_q <= {rem_sub[TIME_BITS-1:0], 1'b0};
				quot_q <= {quot_q[F-1:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			eti_pkg::OP_PREP: begin
				u_q <= u_x;
				e_q <= quot_q;
				neg_q <= span[VALUE_BITS];
				mag_q <= span_abs[VALUE_BITS-1:0];
			end
			eti_pkg::OP_SQ: begin
				sq_q <= mul_frac;
			end
			eti_pkg::OP_CUBE: begin
				e_q <= ease_x;
			end
			eti_pkg::OP_HI: begin
				acc_q <= mul_p[VALUE_BITS-1:0];
			end
			eti_pkg::OP_LO: begin
				acc_q <= acc_q + VALUE_BITS'(mul_p[MUL_P_BITS-1:F]);
			end
			eti_pkg::OP_REPORT: begin
				if (!flags.out_busy) begin
					out_value_q <= present_q;
					out_moving_q <= moving;
				end
			end
			default: begin
			end
		endcase
	end

	`ETI_ASSERT_NEXT(a_busy_after_take, clk, arst_n, accept, !item.ready, "ready held after take")
	`ETI_ASSERT_NOW(a_run_has_total, clk, arst_n, running_q, total_q != '0, "tween without length")
	`ETI_ASSERT_NOW(a_spent_bounded, clk, arst_n, 1'b1, spent_q <= total_q, "elapsed beyond length")
	`ETI_ASSERT_NOW(a_frac_bounded, clk, arst_n, ctrl.op == eti_pkg::OP_HI, e_q <= ONE, "ease above one")

endmodule
